FILE: rtl/pps_pkg.sv
// Shared types, codes and reset values for the power pulse sequencer.
// Depends on nothing; imported by every module of the block.
package pps_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_CHANNELS_DEF = 2;
    localparam int TIMER_BITS_DEF   = 16;

    // Field widths fixed by the stream format
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int OUT_CH      = 2;

    // Command codes carried on s_tuser
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_REQ  = 1'b1;

    // Timing register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_HOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_SETTLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_HOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_SETTLE = 3'd5;

    // Timing register reset values
    localparam logic [CFG_W-1:0] ON_DELAY_RST   = 16'd100;
    localparam logic [CFG_W-1:0] ON_HOLD_RST    = 16'd1000;
    localparam logic [CFG_W-1:0] ON_SETTLE_RST  = 16'd3000;
    localparam logic [CFG_W-1:0] OFF_DELAY_RST  = 16'd100;
    localparam logic [CFG_W-1:0] OFF_HOLD_RST   = 16'd3000;
    localparam logic [CFG_W-1:0] OFF_SETTLE_RST = 16'd3000;

    typedef enum logic [1:0] {
        PH_DELAY  = 2'd0,
        PH_HOLD   = 2'd1,
        PH_SETTLE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] on_delay;
        logic [CFG_W-1:0] on_hold;
        logic [CFG_W-1:0] on_settle;
        logic [CFG_W-1:0] off_delay;
        logic [CFG_W-1:0] off_hold;
        logic [CFG_W-1:0] off_settle;
    } cfg_t;

    // Per-channel command for the item being processed
    typedef struct packed {
        logic fire;     // item is processed this cycle
        logic tick;     // item is a time tick
        logic req;      // item is a request naming this channel
        logic turn_on;  // requested direction
    } step_t;

    // Per-channel state after the step
    typedef struct packed {
        logic key;
        logic powered;
        logic busy;
        logic finished;
        logic started;
    } chan_stat_t;

endpackage

FILE: rtl/module_power_pulse_sequencer.sv
// Path: an item accepted on s_ passes the input register, then the result register, whose
// contents are valid on m_; ticks and power requests alike.
// Throughput: one item per cycle; a channel's next state is one increment and
// one 16-bit compare from its registers. s_tready drops only while a result waits.
// Reset: aresetn synchronous, active low; all channels off and idle, timing
// registers back to their defaults, both stream stages empty.
module module_power_pulse_sequencer
    import pps_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [0] channel, [1] turn_on, rest zero
    input  logic                 s_tuser,   // cmd: 0 tick, 1 power request
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [1:0] key_lines, [3:2] powered,
                                            // [5:4] busy_res, [7:6] finished,
                                            // [8] started, rest zero
    // timing register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int PAD_W = NUM_CHANNELS + OUT_CH;

    cfg_t cfg;

    logic in_valid_reg, in_valid_next;
    logic in_cmd_reg;
    logic in_chan_reg;
    logic in_on_reg;
    logic fire;

    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg,  out_data_next;

    step_t      step  [NUM_CHANNELS];
    chan_stat_t stat  [NUM_CHANNELS];

    logic [NUM_CHANNELS-1:0] key_vec, pwr_vec, busy_vec, fin_vec, start_vec;
    logic [PAD_W-1:0]        key_pad, pwr_pad, busy_pad, fin_pad;

    assign cfg_ready = 1'b1;

    pps_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Process the held request when the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_chan_reg <= s_tdata[0];
            in_on_reg   <= s_tdata[1];
        end
    end

    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
        always_comb begin
            step[i].fire    = fire;
            step[i].tick    = (in_cmd_reg == CMD_TICK);
            step[i].req     = (in_cmd_reg == CMD_REQ) && (i < OUT_CH)
                              && (in_chan_reg == 1'(i));
            step[i].turn_on = in_on_reg;
        end

        pps_channel #(
            .TIMER_BITS (TIMER_BITS)
        ) u_chan (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step    (step[i]),
            .cfg     (cfg),
            .stat    (stat[i])
        );

        assign key_vec[i]   = stat[i].key;
        assign pwr_vec[i]   = stat[i].powered;
        assign busy_vec[i]  = stat[i].busy;
        assign fin_vec[i]   = stat[i].finished;
        assign start_vec[i] = stat[i].started;
    end

    // Drop channels beyond the result width, zero-fill when there are fewer
    assign key_pad  = PAD_W'(key_vec);
    assign pwr_pad  = PAD_W'(pwr_vec);
    assign busy_pad = PAD_W'(busy_vec);
    assign fin_pad  = PAD_W'(fin_vec);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fire) begin
            out_valid_next = 1'b1;
            out_data_next  = M_TDATA_W'({|start_vec, fin_pad[OUT_CH-1:0],
                                         busy_pad[OUT_CH-1:0], pwr_pad[OUT_CH-1:0],
                                         key_pad[OUT_CH-1:0]});
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/pps_cfg_regs.sv
// Timing register file of the power pulse sequencer: six shared tick counts.
// Depends on pps_pkg for the register indexes, reset values and cfg_t.
module pps_cfg_regs
    import pps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_ON_DELAY:   cfg_next.on_delay   = wr_data;
                CFG_ON_HOLD:    cfg_next.on_hold    = wr_data;
                CFG_ON_SETTLE:  cfg_next.on_settle  = wr_data;
                CFG_OFF_DELAY:  cfg_next.off_delay  = wr_data;
                CFG_OFF_HOLD:   cfg_next.off_hold   = wr_data;
                CFG_OFF_SETTLE: cfg_next.off_settle = wr_data;
                default:        cfg_next = cfg_reg;   // drop writes beyond the list
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_delay   <= ON_DELAY_RST;
            cfg_reg.on_hold    <= ON_HOLD_RST;
            cfg_reg.on_settle  <= ON_SETTLE_RST;
            cfg_reg.off_delay  <= OFF_DELAY_RST;
            cfg_reg.off_hold   <= OFF_HOLD_RST;
            cfg_reg.off_settle <= OFF_SETTLE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/pps_channel.sv
// One channel of the power pulse sequencer: phase, tick timer and power state.
// Depends on pps_pkg for phase_t, step_t, cfg_t and chan_stat_t.
module pps_channel
    import pps_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  step_t      step,
    input  cfg_t       cfg,
    output chan_stat_t stat
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    phase_t                phase_reg,   phase_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                  power_reg,   power_next;
    logic                  busy_reg,    busy_next;
    logic                  key_reg,     key_next;
    logic                  fin_next;
    logic                  start_next;

    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CFG_W-1:0]      thr;
    logic                  thr_valid;
    logic                  reached;

    // Threshold of the current phase for the direction being sequenced
    always_comb begin
        thr       = '0;
        thr_valid = 1'b1;
        unique case (phase_reg)
            PH_DELAY:  thr = power_reg ? cfg.off_delay  : cfg.on_delay;
            PH_HOLD:   thr = power_reg ? cfg.off_hold   : cfg.on_hold;
            PH_SETTLE: thr = power_reg ? cfg.off_settle : cfg.on_settle;
            default:   thr_valid = 1'b0;   // count on, never advance
        endcase
    end

    assign elapsed_inc = (elapsed_reg == TIMER_MAX) ? elapsed_reg
                                                    : elapsed_reg + TIMER_BITS'(1);
    assign reached     = thr_valid && (CMP_W'(elapsed_inc) >= CMP_W'(thr));

    // Next state
    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        power_next   = power_reg;
        busy_next    = busy_reg;
        key_next     = key_reg;
        fin_next     = 1'b0;
        start_next   = 1'b0;
        if (step.fire && step.tick && busy_reg) begin
            elapsed_next = elapsed_inc;
            if (reached) begin
                elapsed_next = '0;
                unique case (phase_reg)
                    PH_DELAY: begin
                        key_next   = 1'b1;
                        phase_next = PH_HOLD;
                    end
                    PH_HOLD: begin
                        key_next   = 1'b0;
                        phase_next = PH_SETTLE;
                    end
                    default: begin
                        phase_next = PH_DELAY;
                        power_next = ~power_reg;
                        busy_next  = 1'b0;
                        fin_next   = 1'b1;
                    end
                endcase
            end
        end else if (step.fire && step.req && (power_reg != step.turn_on)) begin
            // a repeat request keeps phase and key, restarts the phase timer
            busy_next    = 1'b1;
            elapsed_next = '0;
            start_next   = 1'b1;
        end
    end

    // Outputs: state as it stands after this step
    always_comb begin
        stat.key      = key_next;
        stat.powered  = power_next;
        stat.busy     = busy_next;
        stat.finished = fin_next;
        stat.started  = start_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DELAY;
            elapsed_reg <= '0;
            power_reg   <= 1'b0;
            busy_reg    <= 1'b0;
            key_reg     <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            power_reg   <= power_next;
            busy_reg    <= busy_next;
            key_reg     <= key_next;
        end
    end

endmodule

FILE: rtl/pps_checker.sv
// Port-level checks for the power pulse sequencer, bound to the top level.
// Depends on pps_pkg for the stream widths.
module pps_checker
    import pps_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Input back-pressure only while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("s_tready low without a stalled result");

    // A key line is only asserted on a busy channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] & ~m_tdata[5:4]) == 2'b00)
        else $error("key line asserted on an idle channel");

    // A finishing channel is no longer busy, and a request never finishes one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:6] & m_tdata[5:4]) == 2'b00
                     && !(m_tdata[8] && (m_tdata[7:6] != 2'b00)))
        else $error("finished flag inconsistent");

endmodule

bind module_power_pulse_sequencer pps_checker u_pps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
